>>> hdl/itbt_pkg.sv
`default_nettype none
// ============================================================================
// itbt_pkg
// Shared types and constants for the integer-to-radix-text converter.
// ============================================================================
package itbt_pkg;

  // Item and result widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned ChrW    = 8;
  localparam int unsigned RadixW  = 5;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned StepW   = 2;
  // Product of a power (at most 2^31) and a radix (at most 16)
  localparam int unsigned ProdW   = DataW + DigitW;

  // Power table: one entry per digit position
  localparam int unsigned PowDepth = 32;
  localparam int unsigned IdxW     = $clog2(PowDepth);

  // Configuration port
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 64;
  localparam int unsigned RegIdxW  = ApbAddrW - 3;

  // Register indexes (byte address / 8)
  localparam logic [RegIdxW-1:0] REG_SYM_LO = 2'd0;
  localparam logic [RegIdxW-1:0] REG_SYM_HI = 2'd1;
  localparam logic [RegIdxW-1:0] REG_RADIX  = 2'd2;

  localparam logic [RadixW-1:0] RadixMin   = 5'd2;
  localparam logic [RadixW-1:0] RadixMax   = 5'd16;
  localparam logic [RadixW-1:0] RadixReset = 5'd2;

  localparam logic [ChrW-1:0] MinusSign = 8'h2D;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SIGN,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic search;
    logic emit_sign;
    logic ram_read;
    logic div_step;
    logic emit_digit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic grow;
    logic negative;
    logic div_done;
    logic idx_zero;
    logic out_free;
  } status_t;

  // Clamp the programmed radix to the supported range
  function automatic logic [RadixW-1:0] eff_radix(input logic [RadixW-1:0] r);
    logic [RadixW-1:0] res;
    res = r;
    if (r < RadixMin) begin
      res = RadixMin;
    end else if (r > RadixMax) begin
      res = RadixMax;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hdl/itbt_ram.sv
`default_nettype none
// ============================================================================
// itbt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module itbt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hdl/itbt_regs.sv
`default_nettype none
// ============================================================================
// itbt_regs
// Configuration registers: symbol alphabet and radix, on an APB-style port.
// ============================================================================
module itbt_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [itbt_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [itbt_pkg::ApbDataW-1:0] pwdata,
  output logic      [itbt_pkg::ApbDataW-1:0] prdata,
  output logic                               pready,
  output logic      [2*itbt_pkg::ApbDataW-1:0] symbols_o,
  output logic      [itbt_pkg::RadixW-1:0]   radix_o
);
  import itbt_pkg::*;

  logic [ApbDataW-1:0] sym_lo_q;
  logic [ApbDataW-1:0] sym_hi_q;
  logic [RadixW-1:0]   radix_q;
  logic [RegIdxW-1:0]  reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:3];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; out-of-range indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_lo_q <= '0;
      sym_hi_q <= '0;
      radix_q  <= RadixReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SYM_LO: sym_lo_q <= pwdata;
        REG_SYM_HI: sym_hi_q <= pwdata;
        REG_RADIX:  radix_q  <= pwdata[RadixW-1:0];
        default: ;
      endcase
    end
  end

  // Readback
  always_comb begin
    unique case (reg_idx)
      REG_SYM_LO: prdata = sym_lo_q;
      REG_SYM_HI: prdata = sym_hi_q;
      REG_RADIX:  prdata = {{(ApbDataW-RadixW){1'b0}}, radix_q};
      default:    prdata = '0;
    endcase
  end

  assign symbols_o = {sym_hi_q, sym_lo_q};
  assign radix_o   = eff_radix(radix_q);

endmodule
`default_nettype wire

>>> hdl/itbt_ctrl.sv
`default_nettype none
// ============================================================================
// itbt_ctrl
// Sequencer: power search, sign, then divide-and-emit per digit.
// ============================================================================
module itbt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire itbt_pkg::status_t status_i,
  output itbt_pkg::cmd_t         cmd_o,
  output itbt_pkg::state_e       state_o
);
  import itbt_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        if (!status_i.grow) begin
          state_d = status_i.negative ? ST_SIGN : ST_LOAD;
        end
      end
      ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.ram_read = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          state_d          = status_i.idx_zero ? ST_IDLE : ST_LOAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign state_o = state_q;

endmodule
`default_nettype wire

>>> hdl/itbt_dp.sv
`default_nettype none
// ============================================================================
// itbt_dp
// Datapath: magnitude, power table, 4-step restoring digit divide, output
// register.
// ============================================================================
module itbt_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [itbt_pkg::DataW-1:0]      value_i,
  input  wire logic [2*itbt_pkg::ApbDataW-1:0] symbols_i,
  input  wire logic [itbt_pkg::RadixW-1:0]     radix_i,
  input  wire itbt_pkg::cmd_t                  cmd_i,
  output itbt_pkg::status_t                    status_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [itbt_pkg::ChrW-1:0]       character_o,
  output logic                                 last_o
);
  import itbt_pkg::*;

  logic [DataW-1:0]  mag_q, mag_d;
  logic              neg_q;
  logic [DataW-1:0]  power_q;
  logic [IdxW-1:0]   idx_q;
  logic [StepW-1:0]  step_q;
  logic [DigitW-1:0] digit_q;
  logic              out_valid_q;
  logic [ChrW-1:0]   char_q;
  logic              last_q;

  logic [ProdW-1:0]  prod;
  logic              grow;
  logic [DataW-1:0]  pw_rd;
  logic [ProdW-1:0]  trial;
  logic              fits;
  logic              out_free;
  logic [ChrW-1:0]   sym;

  // Next power candidate
  assign prod = ProdW'(power_q) * ProdW'(radix_i);
  assign grow = prod <= ProdW'(mag_q);

  // Power table, filled on the way up and read on the way down
  itbt_ram #(
    .Width (DataW),
    .Depth (PowDepth)
  ) u_pow_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.search),
    .waddr_i (idx_q),
    .wdata_i (power_q),
    .re_i    (cmd_i.ram_read),
    .raddr_i (idx_q),
    .rdata_o (pw_rd)
  );

  // One quotient bit per step
  assign trial = ProdW'(pw_rd) << step_q;
  assign fits  = ProdW'(mag_q) >= trial;
  assign mag_d = mag_q - trial[DataW-1:0];

  // Magnitude, sign, power, index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      neg_q   <= value_i[DataW-1];
      mag_q   <= value_i[DataW-1] ? (~value_i + DataW'(1)) : value_i;
      power_q <= DataW'(1);
      idx_q   <= '0;
    end else if (cmd_i.search && grow) begin
      power_q <= prod[DataW-1:0];
      idx_q   <= idx_q + IdxW'(1);
    end else if (cmd_i.div_step && fits) begin
      mag_q <= mag_d;
    end else if (cmd_i.emit_digit && idx_q != '0) begin
      idx_q <= idx_q - IdxW'(1);
    end
  end

  // Divide step counter and quotient digit
  always_ff @(posedge clk_i) begin
    if (cmd_i.ram_read) begin
      step_q  <= '1;
      digit_q <= '0;
    end else if (cmd_i.div_step) begin
      digit_q[step_q] <= fits;
      step_q          <= step_q - StepW'(1);
    end
  end

  // Symbol lookup
  assign sym = symbols_i[{digit_q, 3'b000} +: ChrW];

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= MinusSign;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= sym;
      last_q <= (idx_q == '0);
    end
  end

  assign status_o.grow     = grow;
  assign status_o.negative = neg_q;
  assign status_o.div_done = (step_q == '0);
  assign status_o.idx_zero = (idx_q == '0);
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

>>> hdl/integer_to_base_n_text.sv
`default_nettype none
// ============================================================================
// integer_to_base_n_text
// Signed 32-bit integer to text in a programmable radix, one character per
// output transfer.
// ============================================================================
// One value is taken at a time. For each value the block takes the input
// transfer, grows the power of the radix (one narrow multiply a cycle, each
// power saved to a 32-entry table), emits a leading minus sign if the value
// is negative, then for each digit does a table read, four restoring divide
// steps (one quotient bit each) and the output register load. The sign and
// each digit wait while the output is stalled. Symbols come from the two
// 64-bit alphabet registers; a radix outside 2..16 is clamped to the nearest
// end.
module integer_to_base_n_text (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [itbt_pkg::DataW-1:0]    value_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [itbt_pkg::ChrW-1:0]     character_o,
  output logic                               last_o,
  // Configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [itbt_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [itbt_pkg::ApbDataW-1:0] pwdata,
  output logic      [itbt_pkg::ApbDataW-1:0] prdata,
  output logic                               pready
);
  import itbt_pkg::*;

  logic [2*ApbDataW-1:0] symbols;
  logic [RadixW-1:0]     radix;
  cmd_t                  cmd;
  status_t               status;
  state_e                state;

  // Configuration registers
  itbt_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .symbols_o (symbols),
    .radix_o   (radix)
  );

  // Sequencer
  itbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  // Datapath
  itbt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .symbols_i   (symbols),
    .radix_i     (radix),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // An accepted value always starts the power search
  a_accept_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state == ST_SEARCH)
    else $error("accepted value did not start power search");

  // A digit waits in place while the output register is occupied
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state == ST_EMIT && !status.out_free |=> state == ST_EMIT)
    else $error("digit left emit state while output busy");

  // The search ends in the sign or the first digit read
  a_search_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state == ST_SEARCH && !status.grow |=> state == ST_SIGN || state == ST_LOAD)
    else $error("power search ended in wrong state");

  // No new value while the controller is busy
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state != ST_IDLE |-> in_stall_o)
    else $error("input not stalled while busy");

endmodule
`default_nettype wire
